// ===== hw/rtl/rwas_pkg.sv =====
// ---------------------------------------------------------------------------
// rwas_pkg
// shared types, constants and character codes for the weekday alarm clock
// ---------------------------------------------------------------------------
package rwas_pkg;

   localparam int ALARM_SLOTS   = 3;
   localparam int SLOT_REGS     = 3;
   localparam int CSR_REGS      = SLOT_REGS + 1;
   localparam int CSR_IDX_W     = $clog2(CSR_REGS);
   localparam int CSR_ADDR_W    = CSR_IDX_W + 2;
   localparam int CSR_DATA_W    = 32;
   localparam int SLOT_CNT_W    = $clog2(ALARM_SLOTS + 1);
   localparam int FEED_W        = 2;
   localparam int FEED_MAX      = 3;
   localparam int FRAME_DIGITS  = 7;
   localparam int POS_W         = 3;
   localparam int TPS_RESET     = 20;

   localparam logic [CSR_IDX_W-1:0] REG_TPS = CSR_IDX_W'(0);

   localparam logic [7:0] CHAR_T_LO = 8'h74;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_M_LO = 8'h6D;
   localparam logic [7:0] CHAR_M_UP = 8'h4D;
   localparam logic [7:0] CHAR_L_LO = 8'h6C;
   localparam logic [7:0] CHAR_L_UP = 8'h4C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic       enable;
      logic [6:0] day_mask;
      logic [4:0] hour;
      logic [5:0] minute;
   } slot_type;

   typedef struct packed {
      logic [7:0]                   tps;
      slot_type [ALARM_SLOTS-1:0]   slots;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        weekday_now;
      logic [5:0]        second_now;
      logic [5:0]        minute_now;
      logic [4:0]        hour_now;
      logic              time_valid;
      logic              set_rejected;
      logic              set_done;
      logic              report_time;
      logic [FEED_W-1:0] feed_count;
   } rsp_type;

   localparam int RSP_W     = $bits(rsp_type);
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

   function automatic slot_type slot_reset_value(input int idx);
      slot_type v;
      case (idx)
         0:       v = slot_type'(19'd522752);
         1:       v = slot_type'(19'd306014);
         2:       v = slot_type'(19'd523520);
         default: v = slot_type'(19'd0);
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/rtc_weekday_alarm_with_serial_set_unit.sv =====
// ---------------------------------------------------------------------------
// rtc_weekday_alarm_with_serial_set_unit
// time-of-day clock with weekday alarm slots, set by a serial frame
//
// channel   dir  contents
// req_*     in   stream: tdata rx_byte, tuser opcode
// rsp_*     out  stream: tdata feed, flags and current time
// csr_*     in   register port: divider setting and alarm slots
//
// one request per cycle while no untaken result stalls it; its result is registered
// and shows in the cycle after acceptance. the result register frees in the cycle
// it is taken, so a request can be accepted while the previous result is taken
// reset is synchronous; the clock stands until a valid set frame loads it
// ---------------------------------------------------------------------------
module rtc_weekday_alarm_with_serial_set_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   input  logic                            req_tuser,  // [0] opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] feed_count, [2] report_time, [3] set_done, [4] set_rejected,
   // [5] time_valid, [10:6] hour_now, [16:11] minute_now,
   // [22:17] second_now, [25:23] weekday_now, zero above
   output logic [rwas_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rwas_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rwas_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rwas_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rwas_pkg::*;

   cfg_type cfg;
   rsp_type rsp;

   assign csr_pready = 1'b1;

   rwas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   rwas_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .req_byte   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp);

endmodule

// ===== hw/rtl/rwas_csr.sv =====
// ---------------------------------------------------------------------------
// rwas_csr
// register file for the divider setting and the alarm slots
// ---------------------------------------------------------------------------
module rwas_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rwas_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rwas_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rwas_pkg::CSR_DATA_W-1:0] csr_prdata,
   output rwas_pkg::cfg_type              cfg
);
   import rwas_pkg::*;

   logic [7:0]                 tps_ff;
   slot_type [ALARM_SLOTS-1:0] slot_ff;
   logic [CSR_IDX_W-1:0]       idx;
   logic                       wr;

   assign idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= 8'(TPS_RESET);
         for (int i = 0; i < ALARM_SLOTS; i++) begin
            slot_ff[i] <= slot_reset_value(i);
         end
      end else if (wr) begin
         if (idx == REG_TPS) begin
            tps_ff <= csr_pwdata[7:0];
         end
         for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (i < SLOT_REGS && idx == CSR_IDX_W'(i + 1)) begin
               slot_ff[i] <= slot_type'(csr_pwdata[$bits(slot_type)-1:0]);
            end
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == REG_TPS) begin
         csr_prdata = CSR_DATA_W'(tps_ff);
      end
      for (int i = 0; i < ALARM_SLOTS; i++) begin
         if (i < SLOT_REGS && idx == CSR_IDX_W'(i + 1)) begin
            csr_prdata = CSR_DATA_W'(slot_ff[i]);
         end
      end
   end

   assign cfg.tps   = tps_ff;
   assign cfg.slots = slot_ff;

endmodule

// ===== hw/rtl/rwas_alarm.sv =====
// ---------------------------------------------------------------------------
// rwas_alarm
// counts alarm slots matching a time and weekday, saturated
// ---------------------------------------------------------------------------
module rwas_alarm (
   input  rwas_pkg::cfg_type             cfg,
   input  logic [4:0]                    hour,
   input  logic [5:0]                    minute,
   input  logic [2:0]                    weekday,
   output logic [rwas_pkg::FEED_W-1:0]   feed_count
);
   import rwas_pkg::*;

   logic [SLOT_CNT_W-1:0] cnt;
   logic [7:0]            mask_ext;

   always_comb begin
      cnt = '0;
      mask_ext = '0;
      for (int i = 0; i < ALARM_SLOTS; i++) begin
         mask_ext = {1'b0, cfg.slots[i].day_mask};
         if (cfg.slots[i].enable && cfg.slots[i].hour == hour &&
             cfg.slots[i].minute == minute && mask_ext[weekday]) begin
            cnt = cnt + SLOT_CNT_W'(1);
         end
      end
      if (int'(cnt) > FEED_MAX) begin
         feed_count = FEED_W'(FEED_MAX);
      end else begin
         feed_count = FEED_W'(cnt);
      end
   end

endmodule

// ===== hw/rtl/rwas_core.sv =====
// ---------------------------------------------------------------------------
// rwas_core
// time counters, serial set frame decoder and result register
// ---------------------------------------------------------------------------
module rwas_core (
   input  logic              clock,
   input  logic              reset,
   input  rwas_pkg::cfg_type cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_opcode,
   input  logic [7:0]        req_byte,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output rwas_pkg::rsp_type rsp
);
   import rwas_pkg::*;

   logic [7:0]       div_ff, div_in;
   logic [5:0]       sec_ff, sec_in, min_ff, min_in;
   logic [4:0]       hour_ff, hour_in;
   logic [2:0]       wday_ff, wday_in;
   logic             run_ff, run_in, fed_ff, fed_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       dig_ff [FRAME_DIGITS-1];
   logic [3:0]       dig_in [FRAME_DIGITS-1];
   logic             vld_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             fire, sec_step, is_t, is_digit;
   logic [3:0]       val;
   logic [5:0]       tk_sec, tk_min;
   logic [4:0]       tk_hour;
   logic [2:0]       tk_wday;
   logic [6:0]       set_h, set_m, set_s;
   logic [FEED_W-1:0] alarm_cnt;

   assign fire       = req_tvalid & req_tready;
   assign req_tready = ~vld_ff | rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp        = rsp_ff;

   assign sec_step = ({1'b0, div_ff} + 9'd1) >= {1'b0, cfg.tps};
   assign is_t     = (req_byte == CHAR_T_LO) || (req_byte == CHAR_T_UP);
   assign is_digit = (req_byte >= CHAR_ZERO) && (req_byte <= CHAR_NINE);
   assign val      = 4'(req_byte - CHAR_ZERO);

   // seconds, minutes, hours and weekday cascade
   always_comb begin
      tk_sec  = sec_ff;
      tk_min  = min_ff;
      tk_hour = hour_ff;
      tk_wday = wday_ff;
      if (sec_ff == 6'd59) begin
         tk_sec = '0;
         if (min_ff == 6'd59) begin
            tk_min = '0;
            if (hour_ff == 5'd23) begin
               tk_hour = '0;
               tk_wday = (wday_ff == 3'd6) ? 3'd0 : wday_ff + 3'd1;
            end else begin
               tk_hour = hour_ff + 5'd1;
            end
         end else begin
            tk_min = min_ff + 6'd1;
         end
      end else begin
         tk_sec = sec_ff + 6'd1;
      end
   end

   rwas_alarm u_alarm (
      .cfg        (cfg),
      .hour       (tk_hour),
      .minute     (tk_min),
      .weekday    (tk_wday),
      .feed_count (alarm_cnt)
   );

   assign set_h = 7'(dig_ff[0]) * 7'd10 + 7'(dig_ff[1]);
   assign set_m = 7'(dig_ff[2]) * 7'd10 + 7'(dig_ff[3]);
   assign set_s = 7'(dig_ff[4]) * 7'd10 + 7'(dig_ff[5]);

   always_comb begin
      div_in  = div_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      wday_in = wday_ff;
      run_in  = run_ff;
      fed_in  = fed_ff;
      pos_in  = pos_ff;
      dig_in  = dig_ff;
      rsp_in  = '0;
      if (fire) begin
         if (opcode_type'(req_opcode) == OP_TICK) begin
            if (run_ff) begin
               if (!sec_step) begin
                  div_in = div_ff + 8'd1;
               end else begin
                  div_in  = '0;
                  sec_in  = tk_sec;
                  min_in  = tk_min;
                  hour_in = tk_hour;
                  wday_in = tk_wday;
                  if (tk_sec != 6'd0) begin
                     fed_in = 1'b0;
                  end else if (!fed_ff) begin
                     fed_in = 1'b1;
                     rsp_in.feed_count = alarm_cnt;
                  end
               end
            end
         end else if (is_t) begin
            if (pos_ff != '0 || !run_ff || is_t) begin
               pos_in = POS_W'(1);
            end
         end else if (pos_ff != '0) begin
            // frame in progress
            if (!is_digit) begin
               pos_in = '0;
               rsp_in.set_rejected = 1'b1;
            end else if (pos_ff != POS_W'(FRAME_DIGITS)) begin
               for (int i = 0; i < FRAME_DIGITS - 1; i++) begin
                  if (pos_ff == POS_W'(i + 1)) begin
                     dig_in[i] = val;
                  end
               end
               pos_in = pos_ff + POS_W'(1);
            end else begin
               pos_in = '0;
               if (set_h > 7'd23 || set_m > 7'd59 || set_s > 7'd59 || val > 4'd6) begin
                  rsp_in.set_rejected = 1'b1;
               end else begin
                  hour_in = set_h[4:0];
                  min_in  = set_m[5:0];
                  sec_in  = set_s[5:0];
                  wday_in = val[2:0];
                  run_in  = 1'b1;
                  fed_in  = 1'b0;
                  rsp_in.set_done = 1'b1;
               end
            end
         end else if (run_ff) begin
            if (req_byte == CHAR_M_LO || req_byte == CHAR_M_UP) begin
               rsp_in.feed_count = FEED_W'(1);
            end else if (req_byte == CHAR_L_LO || req_byte == CHAR_L_UP) begin
               rsp_in.report_time = 1'b1;
            end
         end
      end
      rsp_in.time_valid  = run_in;
      rsp_in.hour_now    = hour_in;
      rsp_in.minute_now  = min_in;
      rsp_in.second_now  = sec_in;
      rsp_in.weekday_now = wday_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= '0;
         sec_ff  <= '0;
         min_ff  <= '0;
         hour_ff <= '0;
         wday_ff <= '0;
         run_ff  <= 1'b0;
         fed_ff  <= 1'b0;
         pos_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         div_ff  <= div_in;
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
         wday_ff <= wday_in;
         run_ff  <= run_in;
         fed_ff  <= fed_in;
         pos_ff  <= pos_in;
         if (fire) begin
            vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== bench/rtc_weekday_alarm_with_serial_set_unit_tb.sv =====
// ---------------------------------------------------------------------------
// rtc_weekday_alarm_with_serial_set_unit_tb
// self-checking bench for the weekday alarm clock with serial time set
//
// a board object keeps its own copy of the clock, frame parser and alarm
// slots, predicts one result per accepted request and compares every result
// field by field in order. stimulus is a short directed run followed by
// phases of random ticks, set frames aimed at alarm times, broken frames,
// commands and noise, with the divider and slots rewritten between phases.
// both stream sides idle at random; the result side also holds off once for
// a long stretch so the request side backs up.
// ---------------------------------------------------------------------------
module rtc_weekday_alarm_with_serial_set_unit_tb;
   import rwas_pkg::*;

   localparam int REG_SLOT0  = 1;
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 120;

   class time_and_feed_board;
      logic [7:0] tps;
      slot_type   slot [ALARM_SLOTS];
      logic [7:0] divider;
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hr;
      logic [2:0] wd;
      bit         running;
      bit         fed;
      logic [3:0] fpos;
      logic [3:0] digits [FRAME_DIGITS];
      rsp_type    expected_times [$];
      int         errors;

      function new();
         tps = 8'(TPS_RESET);
         for (int i = 0; i < ALARM_SLOTS; i++) begin
            case (i)
               0:       slot[i] = slot_type'(19'd522752);
               1:       slot[i] = slot_type'(19'd306014);
               2:       slot[i] = slot_type'(19'd523520);
               default: slot[i] = slot_type'(19'd0);
            endcase
         end
         divider = '0;
         sec     = '0;
         min     = '0;
         hr      = '0;
         wd      = '0;
         running = 1'b0;
         fed     = 1'b0;
         fpos    = '0;
         foreach (digits[i]) digits[i] = '0;
         errors  = 0;
      endfunction

      function void write_reg(input int idx, input logic [31:0] value);
         if (idx == REG_TPS)
            tps = value[7:0];
         else if (idx >= REG_SLOT0 && idx - REG_SLOT0 < ALARM_SLOTS)
            slot[idx - REG_SLOT0] = slot_type'(value[18:0]);
      endfunction

      function int count_alarms();
         int n;
         n = 0;
         foreach (slot[i]) begin
            if (slot[i].enable && slot[i].hour == hr && slot[i].minute == min &&
                slot[i].day_mask[wd])
               n++;
         end
         return (n > FEED_MAX) ? FEED_MAX : n;
      endfunction

      function int advance_tick();
         int feeds;
         feeds = 0;
         if (!running) return 0;
         if ({1'b0, divider} + 9'd1 < {1'b0, tps}) begin
            divider = divider + 8'd1;
            return 0;
         end
         divider = '0;
         sec = sec + 6'd1;
         if (sec >= 6'd60) begin
            sec = '0;
            min = min + 6'd1;
            if (min >= 6'd60) begin
               min = '0;
               hr = hr + 5'd1;
               if (hr >= 5'd24) begin
                  hr = '0;
                  wd = wd + 3'd1;
                  if (wd >= 3'd7) wd = '0;
               end
            end
         end
         if (sec != 6'd0) begin
            fed = 1'b0;
         end else if (!fed) begin
            fed = 1'b1;
            feeds = count_alarms();
         end
         return feeds;
      endfunction

      function void parse_frame_byte(input logic [7:0] c, output bit done, output bit rej);
         int h, m, s, w;
         done = 1'b0;
         rej  = 1'b0;
         if (c == CHAR_T_LO || c == CHAR_T_UP) begin
            fpos = 4'd1;
            return;
         end
         if (fpos == 4'd0) return;
         if (c < CHAR_ZERO || c > CHAR_NINE || fpos > 4'd7) begin
            fpos = '0;
            rej = 1'b1;
            return;
         end
         digits[fpos - 4'd1] = 4'(c - CHAR_ZERO);
         fpos = fpos + 4'd1;
         if (fpos < 4'd8) return;
         fpos = '0;
         h = digits[0] * 10 + digits[1];
         m = digits[2] * 10 + digits[3];
         s = digits[4] * 10 + digits[5];
         w = digits[6];
         if (h > 23 || m > 59 || s > 59 || w > 6) begin
            rej = 1'b1;
            return;
         end
         hr      = 5'(h);
         min     = 6'(m);
         sec     = 6'(s);
         wd      = 3'(w);
         running = 1'b1;
         fed     = 1'b0;
         done    = 1'b1;
      endfunction

      function void take_request(input opcode_type op, input logic [7:0] c);
         rsp_type e;
         int feeds;
         bit done, rej, report;
         feeds  = 0;
         done   = 1'b0;
         rej    = 1'b0;
         report = 1'b0;
         if (op == OP_TICK)
            feeds = advance_tick();
         else if (fpos != 4'd0 || !running)
            parse_frame_byte(c, done, rej);
         else if (c == CHAR_M_LO || c == CHAR_M_UP)
            feeds = 1;
         else if (c == CHAR_L_LO || c == CHAR_L_UP)
            report = 1'b1;
         else if (c == CHAR_T_LO || c == CHAR_T_UP)
            parse_frame_byte(c, done, rej);
         e.feed_count   = FEED_W'(feeds);
         e.report_time  = report;
         e.set_done     = done;
         e.set_rejected = rej;
         e.time_valid   = running;
         e.hour_now     = hr;
         e.minute_now   = min;
         e.second_now   = sec;
         e.weekday_now  = wd;
         expected_times.push_back(e);
      endfunction

      task flag_mismatch(input string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task compare_field(input string name, input logic [31:0] got,
                         input logic [31:0] want);
         if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task take_result(input logic [RSP_DATA_W-1:0] d);
         rsp_type e, g;
         if (expected_times.size() == 0) begin
            flag_mismatch("result with no request waiting");
            return;
         end
         e = expected_times.pop_front();
         g = rsp_type'(d[RSP_W-1:0]);
         compare_field("feed_count", 32'(g.feed_count), 32'(e.feed_count));
         compare_field("report_time", 32'(g.report_time), 32'(e.report_time));
         compare_field("set_done", 32'(g.set_done), 32'(e.set_done));
         compare_field("set_rejected", 32'(g.set_rejected), 32'(e.set_rejected));
         compare_field("time_valid", 32'(g.time_valid), 32'(e.time_valid));
         compare_field("hour_now", 32'(g.hour_now), 32'(e.hour_now));
         compare_field("minute_now", 32'(g.minute_now), 32'(e.minute_now));
         compare_field("second_now", 32'(g.second_now), 32'(e.second_now));
         compare_field("weekday_now", 32'(g.weekday_now), 32'(e.weekday_now));
         compare_field("padding", 32'(d >> RSP_W), 32'd0);
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   time_and_feed_board feed_board;
   int counted_items = 0;
   bit dense = 1'b0;
   int idle_cycles = 0;

   rtc_weekday_alarm_with_serial_set_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : rsp_side
      int stall_left;
      int quiet_left;
      int taken;
      int r;
      bit held;
      stall_left = 0;
      quiet_left = 0;
      taken = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            feed_board.take_result(rsp_tdata);
            taken++;
         end
         if (!held && taken >= 300 && req_tvalid) begin
            held = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (quiet_left > 0) begin
               quiet_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 20)
                  stall_left = $urandom_range(1, 3);
               else if (r < 23)
                  stall_left = $urandom_range(10, 40);
               else if (r < 26)
                  quiet_left = $urandom_range(20, 100);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (dense) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] digit_char(input int d);
      return CHAR_ZERO + 8'(d);
   endfunction

   function automatic logic [7:0] start_char();
      return ($urandom_range(0, 1) == 0) ? CHAR_T_LO : CHAR_T_UP;
   endfunction

   function automatic logic [7:0] non_digit_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_T_LO || c == CHAR_T_UP);
      return c;
   endfunction

   task automatic send_request(input opcode_type op, input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      feed_board.take_request(op, data);
   endtask

   task automatic send_tick();
      send_request(OP_TICK, 8'($urandom_range(0, 255)));
      counted_items++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_request(OP_BYTE, c);
      counted_items++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_tick();
   endtask

   task automatic send_frame(input int h, input int m, input int s, input int w);
      send_byte(start_char());
      send_byte(digit_char(h / 10));
      send_byte(digit_char(h % 10));
      send_byte(digit_char(m / 10));
      send_byte(digit_char(m % 10));
      send_byte(digit_char(s / 10));
      send_byte(digit_char(s % 10));
      send_byte(digit_char(w));
   endtask

   task automatic write_csr(input int idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      feed_board.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (feed_board.expected_times.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic slot_type random_slot();
      slot_type s;
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         s.enable   = 1'b1;
         s.day_mask = ($urandom_range(0, 3) == 0) ? 7'h7F : 7'($urandom_range(0, 127));
         s.hour     = 5'($urandom_range(0, 23));
         s.minute   = 6'($urandom_range(0, 59));
      end else if (r < 80) begin
         s = slot_type'(19'd0);
      end else if (r < 88) begin
         s = slot_type'(19'h7FFFF);
      end else begin
         s = slot_type'(19'($urandom_range(0, 19'h7FFFF)));
      end
      return s;
   endfunction

   task automatic set_phase(input int p);
      logic [7:0]  tps;
      logic [31:0] value;
      slot_type    s [ALARM_SLOTS];
      case (p)
         1:       tps = 8'd1;
         2:       tps = 8'd0;
         3:       tps = 8'd255;
         4:       tps = 8'd2;
         5:       tps = 8'($urandom_range(3, 9));
         default: tps = 8'd1;
      endcase
      foreach (s[i]) s[i] = random_slot();
      if (p == 3) begin
         s[0] = slot_type'(19'd0);
         s[1] = slot_type'(19'h7FFFF);
      end else if (p == 5) begin
         s[0].enable = 1'b1;
         s[1] = s[0];
      end else if (p == PHASES) begin
         s[0].enable   = 1'b1;
         s[0].day_mask = 7'h7F;
         s[0].hour     = 5'($urandom_range(0, 23));
         s[0].minute   = 6'($urandom_range(0, 59));
         foreach (s[i]) s[i] = s[0];
      end
      value = $urandom();
      value[7:0] = tps;
      write_csr(REG_TPS, value);
      foreach (s[i]) begin
         value = $urandom();
         value[18:0] = s[i];
         write_csr(REG_SLOT0 + i, value);
      end
   endtask

   task automatic send_aimed_frame();
      slot_type s;
      int h, m, ss, w, total, tps_eff;
      s = feed_board.slot[$urandom_range(0, ALARM_SLOTS - 1)];
      if (s.hour <= 23 && s.minute <= 59) begin
         h = s.hour;
         m = s.minute;
      end else begin
         h = $urandom_range(0, 23);
         m = $urandom_range(0, 59);
      end
      total = (h * 60 + m + 1439) % 1440;
      ss = $urandom_range(55, 59);
      if (s.day_mask != 7'd0 && $urandom_range(0, 3) != 0) begin
         do w = $urandom_range(0, 6); while (!s.day_mask[w]);
      end else begin
         w = $urandom_range(0, 6);
      end
      send_frame(total / 60, total % 60, ss, w);
      tps_eff = (feed_board.tps == 8'd0) ? 1 : feed_board.tps;
      if (tps_eff <= 20)
         send_ticks((60 - ss) * tps_eff + $urandom_range(0, 3));
      else
         send_ticks($urandom_range(1, 20));
   endtask

   task automatic send_broken_frame();
      logic [7:0] b [8];
      int len, k, mode;
      b[0] = start_char();
      for (int i = 1; i < 8; i++) b[i] = digit_char($urandom_range(0, 9));
      len = 8;
      mode = $urandom_range(0, 4);
      k = $urandom_range(1, 7);
      case (mode)
         1: b[k] = non_digit_char();
         2: b[k] = start_char();
         3: len = $urandom_range(1, 7);
         4: begin
            // one field forced just out of range; the other fields may fall out of range too
            b[1] = digit_char($urandom_range(0, 9));
            b[2] = digit_char($urandom_range(0, 5));
            b[4] = digit_char($urandom_range(0, 5));
            b[7] = digit_char($urandom_range(0, 6));
            b[5] = digit_char($urandom_range(0, 9));
            b[3] = digit_char($urandom_range(0, 9));
            b[6] = digit_char($urandom_range(0, 9));
            b[1] = digit_char($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: begin b[1] = digit_char(2); b[2] = digit_char($urandom_range(4, 9)); end
               1: b[3] = digit_char($urandom_range(6, 9));
               2: b[5] = digit_char($urandom_range(6, 9));
               default: b[7] = digit_char($urandom_range(7, 9));
            endcase
         end
         default: ;
      endcase
      for (int i = 0; i < len; i++) send_byte(b[i]);
   endtask

   task automatic run_random(input int goal);
      int target, r, n;
      target = counted_items + goal;
      while (counted_items < target) begin
         dense = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 35) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 25);
            send_ticks(n);
         end else if (r < 60) begin
            send_aimed_frame();
         end else if (r < 70) begin
            case ($urandom_range(0, 5))
               0:       send_frame(0, 0, 0, 0);
               1:       send_frame(23, 59, 59, 6);
               default: send_frame($urandom_range(0, 23), $urandom_range(0, 59),
                                   $urandom_range(0, 59), $urandom_range(0, 6));
            endcase
         end else if (r < 78) begin
            send_broken_frame();
         end else if (r < 90) begin
            case ($urandom_range(0, 3))
               0:       send_byte(CHAR_M_LO);
               1:       send_byte(CHAR_M_UP);
               2:       send_byte(CHAR_L_LO);
               default: send_byte(CHAR_L_UP);
            endcase
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      dense = 1'b0;
   endtask

   task automatic run_directed();
      send_tick();
      send_byte(CHAR_M_LO);
      send_byte(8'h00);
      // abort on a non-digit right after the start character
      send_byte(CHAR_T_LO);
      send_byte(CHAR_NINE + 8'd1);
      // restart mid-frame, then set 23:59:59 on the last weekday
      send_byte(CHAR_T_UP);
      send_frame(23, 59, 59, 6);
      send_byte(CHAR_M_UP);
      send_byte(CHAR_L_LO);
      send_byte(8'hFF);
      // hour out of range, ended by a non-digit in the weekday place
      send_byte(CHAR_T_LO);
      send_byte(digit_char(9));
      send_byte(digit_char(9));
      repeat (4) send_byte(CHAR_ZERO);
      send_byte(CHAR_ZERO - 8'd1);
   endtask

   initial begin : stimulus
      feed_board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(PHASE_ITEMS);
      for (int p = 1; p <= PHASES; p++) begin
         drain_results();
         set_phase(p);
         run_random(PHASE_ITEMS);
      end
      drain_results();
      if (feed_board.errors == 0 && feed_board.expected_times.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== rtc_weekday_alarm_with_serial_set_unit.f =====
hw/rtl/rwas_pkg.sv
hw/rtl/rwas_csr.sv
hw/rtl/rwas_alarm.sv
hw/rtl/rwas_core.sv
hw/rtl/rtc_weekday_alarm_with_serial_set_unit.sv
bench/rtc_weekday_alarm_with_serial_set_unit_tb.sv
